// ===== hw/rtl/qdft_pkg.sv =====
`default_nettype none

package qdft_pkg;

  // Default configuration
  localparam int COORD_BITS_DEF  = 16;
  localparam int RATING_FRAC_DEF = 16;

  // Rating format: unsigned Q0.16, saturating
  localparam int                     RATING_BITS = 16;
  localparam logic [RATING_BITS-1:0] RATING_MAX  = '1;

  // Side lengths carry this many fraction bits
  localparam int LEN_FRAC = 8;

  // 6*sqrt(3) in Q.28
  localparam int                   K6R3_BITS = 32;
  localparam int                   K6R3_FRAC = 28;
  localparam logic [K6R3_BITS-1:0] K6R3      = 32'd2789663090;

  // Root bits resolved per pipeline stage
  localparam int SQRT_STEPS = 3;

  // Register stages of the rating unit: products, numerator, range check, quotient bits
  localparam int RATE_LAT = 3 + RATING_BITS;

endpackage

`default_nettype wire

// ===== hw/rtl/qdft_isqrt.sv =====
`default_nettype none

module qdft_isqrt #(
  parameter int IW   = 33,
  parameter int RB   = 25,
  parameter int SPS  = 3,
  parameter int FRAC = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] v,
  output logic [RB-1:0] root
);

  localparam int NS = (RB + SPS - 1) / SPS;
  localparam int TS = NS * SPS;
  localparam int XW = 2 * TS;
  localparam int RW = RB + 2;

  typedef struct packed {
    logic [RB-1:0] root;
    logic [RW-1:0] rem;
    logic [XW-1:0] xs;
  } sq_t;

  // Resolve SPS root bits, one bit pair of the radicand each
  function automatic sq_t sq_stage(input sq_t s);
    sq_t           r;
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    r = s;
    for (int k = 0; k < SPS; k++) begin
      rem_t = {r.rem, r.xs[XW-1 -: 2]};
      trial = (RW+2)'({r.root, 2'b01});
      if (rem_t >= trial) begin
        r.rem  = RW'(rem_t - trial);
        r.root = {r.root[RB-2:0], 1'b1};
      end else begin
        r.rem  = RW'(rem_t);
        r.root = {r.root[RB-2:0], 1'b0};
      end
      r.xs = r.xs << 2;
    end
    return r;
  endfunction

  sq_t st_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    sq_t st_i;
    if (s == 0) begin : g_head
      assign st_i = '{root: '0, rem: '0, xs: XW'(v) << FRAC};
    end else begin : g_tail
      assign st_i = st_q[s-1];
    end

    // Advance one stage of the root
    always_ff @(posedge clk) begin
      if (en) begin
        st_q[s] <= sq_stage(st_i);
      end
    end
  end

  assign root = st_q[NS-1].root;

endmodule

`default_nettype wire

// ===== hw/rtl/qdft_rating.sv =====
`default_nettype none

module qdft_rating #(
  parameter int AXB  = 33,
  parameter int PB   = 27,
  parameter int FRAC = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [AXB-1:0]                   ax,
  input  logic [PB-1:0]                    per,
  output logic [qdft_pkg::RATING_BITS-1:0] rating
);

  import qdft_pkg::*;

  localparam int LOB = (AXB + 1) / 2;
  localparam int HIB = AXB - LOB;
  localparam int KX  = K6R3_BITS + AXB;
  localparam int SHN = 2 * LEN_FRAC + FRAC - K6R3_FRAC;
  localparam int SHL = (SHN > 0) ? SHN : 0;
  localparam int SHR = (SHN < 0) ? -SHN : 0;
  localparam int NB  = KX + SHL;
  localparam int DB  = 2 * PB;
  localparam int W   = (NB > DB + RATING_BITS) ? NB : DB + RATING_BITS;

  // Products: constant times twice the area in two halves, perimeter squared
  logic [K6R3_BITS+LOB-1:0] pl;
  logic [K6R3_BITS+HIB-1:0] ph;
  logic [DB-1:0]            dq;
  logic                     z1;

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= (K6R3_BITS+LOB)'(K6R3) * (K6R3_BITS+LOB)'(ax[LOB-1:0]);
      ph <= (K6R3_BITS+HIB)'(K6R3) * (K6R3_BITS+HIB)'(ax[AXB-1:LOB]);
      dq <= DB'(per) * DB'(per);
      z1 <= (per == '0);
    end
  end

  // Join the halves and align the numerator to the divisor
  logic [KX-1:0] kax;
  logic [W-1:0]  n2;
  logic [DB-1:0] d2;
  logic          z2;

  assign kax = (KX'(ph) << LOB) + KX'(pl);

  always_ff @(posedge clk) begin
    if (en) begin
      n2 <= W'((NB'(kax) << SHL) >> SHR);
      d2 <= dq;
      z2 <= z1;
    end
  end

  // Range check: quotient of 2^16 or more saturates
  logic [W-1:0]  rem3;
  logic [DB-1:0] d3;
  logic          z3;
  logic          sat3;

  always_ff @(posedge clk) begin
    if (en) begin
      rem3 <= n2;
      d3   <= d2;
      z3   <= z2;
      sat3 <= (n2 >= (W'(d2) << RATING_BITS));
    end
  end

  // Restoring division, one quotient bit per stage
  logic [W-1:0]           rem_q [RATING_BITS-1];
  logic [DB-1:0]          d_q   [RATING_BITS-1];
  logic [RATING_BITS-1:0] q_q   [RATING_BITS];
  logic                   sat_q [RATING_BITS];
  logic                   z_q   [RATING_BITS];

  for (genvar i = 0; i < RATING_BITS; i++) begin : g_div
    localparam int B = RATING_BITS - 1 - i;
    logic [W-1:0]           rem_i;
    logic [W-1:0]           trial;
    logic [DB-1:0]          d_i;
    logic [RATING_BITS-1:0] q_i;
    logic                   sat_i;
    logic                   z_i;
    logic                   ge;

    if (i == 0) begin : g_head
      assign rem_i = rem3;
      assign d_i   = d3;
      assign q_i   = '0;
      assign sat_i = sat3;
      assign z_i   = z3;
    end else begin : g_tail
      assign rem_i = rem_q[i-1];
      assign d_i   = d_q[i-1];
      assign q_i   = q_q[i-1];
      assign sat_i = sat_q[i-1];
      assign z_i   = z_q[i-1];
    end

    assign trial = W'(d_i) << B;
    assign ge    = (rem_i >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[i]   <= q_i | (RATING_BITS'(ge) << B);
        sat_q[i] <= sat_i;
        z_q[i]   <= z_i;
      end
    end

    if (i < RATING_BITS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= ge ? rem_i - trial : rem_i;
          d_q[i]   <= d_i;
        end
      end
    end
  end

  // Zero perimeter wins over saturation
  assign rating = z_q[RATING_BITS-1]   ? '0 :
                  sat_q[RATING_BITS-1] ? RATING_MAX : q_q[RATING_BITS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/quad_diagonal_flip_test_unit.sv =====
`default_nettype none

// Quad diagonal flip test. Each word on the input channel is one quad A,B,C,D whose
// present diagonal is B-D; the result word tells whether the quad is strictly convex,
// the minimum shape rating of triangles ABD/BCD and of ABC/CDA (area over perimeter
// squared, equilateral = 1.0, unsigned Q0.16 saturating at 65535), and whether to
// flip to diagonal A-C. One quad is taken every clock cycle; each quad passes through the
// pipelined side-length square roots (three root bits per stage) followed by the
// sixteen-stage rating divider. The whole pipeline holds as one while a result waits
// under out_stall, so in_stall follows out_stall only when a result is pending at the
// output.

module quad_diagonal_flip_test_unit #(
  parameter int COORD_BITS       = qdft_pkg::COORD_BITS_DEF,
  parameter int RATING_FRAC_BITS = qdft_pkg::RATING_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     a_x,
  input  logic signed [COORD_BITS-1:0]     a_z,
  input  logic signed [COORD_BITS-1:0]     b_x,
  input  logic signed [COORD_BITS-1:0]     b_z,
  input  logic signed [COORD_BITS-1:0]     c_x,
  input  logic signed [COORD_BITS-1:0]     c_z,
  input  logic signed [COORD_BITS-1:0]     d_x,
  input  logic signed [COORD_BITS-1:0]     d_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_convex,
  output logic                             do_flip,
  output logic [qdft_pkg::RATING_BITS-1:0] current_rating,
  output logic [qdft_pkg::RATING_BITS-1:0] other_rating
);

  import qdft_pkg::*;

  localparam int DW  = COORD_BITS + 1;      // coordinate difference
  localparam int VW  = 2 * COORD_BITS + 1;  // squared length
  localparam int AXB = 2 * COORD_BITS + 1;  // twice the area
  localparam int RB  = COORD_BITS + 9;      // side length, Q.8
  localparam int PB  = RB + 2;              // perimeter
  localparam int NS  = (RB + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int RL  = RATE_LAT;
  localparam int LAT = 6 + NS + RL;

  // Edge vectors: AB, BC, CD, DA, BD, AC
  localparam int E_TO [6] = '{1, 2, 3, 0, 3, 2};
  localparam int E_FR [6] = '{0, 1, 2, 3, 1, 0};
  // Corner turns as cross products of edge vectors (turn at A, B, C, D)
  localparam int T_U [4] = '{4, 0, 1, 5};
  localparam int T_W [4] = '{3, 5, 4, 2};

  function automatic logic [AXB-1:0] mag(input logic signed [2*DW-1:0] x);
    return AXB'((x < 0) ? -x : x);
  endfunction

  logic          en;
  logic [LAT-1:0] vq;

  // Whole pipeline moves unless a finished word is held at the output
  assign en        = !(vq[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vq[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[LAT-2:0], in_valid};
    end
  end

  // Capture the corners
  logic signed [COORD_BITS-1:0] px [4];
  logic signed [COORD_BITS-1:0] pz [4];

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= a_x;  pz[0] <= a_z;
      px[1] <= b_x;  pz[1] <= b_z;
      px[2] <= c_x;  pz[2] <= c_z;
      px[3] <= d_x;  pz[3] <= d_z;
    end
  end

  // Edge vectors
  logic signed [DW-1:0] ex [6];
  logic signed [DW-1:0] ez [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        ex[i] <= DW'(px[E_TO[i]]) - DW'(px[E_FR[i]]);
        ez[i] <= DW'(pz[E_TO[i]]) - DW'(pz[E_FR[i]]);
      end
    end
  end

  // Squares and cross terms
  logic signed [2*DW-1:0] sqx [6];
  logic signed [2*DW-1:0] sqz [6];
  logic signed [2*DW-1:0] cpa [4];
  logic signed [2*DW-1:0] cpb [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sqx[i] <= ex[i] * ex[i];
        sqz[i] <= ez[i] * ez[i];
      end
      for (int t = 0; t < 4; t++) begin
        cpa[t] <= ex[T_U[t]] * ez[T_W[t]];
        cpb[t] <= ez[T_U[t]] * ex[T_W[t]];
      end
    end
  end

  // Squared lengths and corner turns
  logic [VW-1:0]          vsum [6];
  logic signed [2*DW-1:0] turn [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        vsum[i] <= VW'(sqx[i]) + VW'(sqz[i]);
      end
      for (int t = 0; t < 4; t++) begin
        turn[t] <= cpa[t] - cpb[t];
      end
    end
  end

  // Convexity and triangle areas in rating order ABD, BCD, ABC, CDA
  logic [3:0]     gt;
  logic [3:0]     lt;
  logic [AXB-1:0] ax5 [4];
  logic           cvx5;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      gt[t] = (turn[t] > 0);
      lt[t] = (turn[t] < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax5[0] <= mag(turn[0]);
      ax5[1] <= mag(turn[2]);
      ax5[2] <= mag(turn[1]);
      ax5[3] <= mag(turn[3]);
      cvx5   <= (&gt) || (&lt);
    end
  end

  // Hold areas and flag alongside the roots
  logic [AXB-1:0] ax_d [NS-1][4];
  logic [NS-2:0]  cvx_d;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_d[0]  <= ax5;
      cvx_d[0] <= cvx5;
      for (int i = 1; i < NS - 1; i++) begin
        ax_d[i]  <= ax_d[i-1];
        cvx_d[i] <= cvx_d[i-1];
      end
    end
  end

  // Side lengths
  logic [RB-1:0] rt [6];

  for (genvar i = 0; i < 6; i++) begin : g_len
    qdft_isqrt #(
      .IW  (VW),
      .RB  (RB),
      .SPS (SQRT_STEPS),
      .FRAC(2 * LEN_FRAC)
    ) u_isqrt (
      .clk (clk),
      .en  (en),
      .v   (vsum[i]),
      .root(rt[i])
    );
  end

  // Perimeters
  logic [PB-1:0]  per [4];
  logic [AXB-1:0] axs [4];
  logic           cvx_sp;

  always_ff @(posedge clk) begin
    if (en) begin
      per[0] <= PB'(rt[0]) + PB'(rt[3]) + PB'(rt[4]);
      per[1] <= PB'(rt[1]) + PB'(rt[2]) + PB'(rt[4]);
      per[2] <= PB'(rt[0]) + PB'(rt[1]) + PB'(rt[5]);
      per[3] <= PB'(rt[2]) + PB'(rt[3]) + PB'(rt[5]);
      axs    <= ax_d[NS-2];
      cvx_sp <= cvx_d[NS-2];
    end
  end

  // Triangle ratings
  logic [RATING_BITS-1:0] rate [4];

  for (genvar k = 0; k < 4; k++) begin : g_rate
    qdft_rating #(
      .AXB (AXB),
      .PB  (PB),
      .FRAC(RATING_FRAC_BITS)
    ) u_rating (
      .clk   (clk),
      .en    (en),
      .ax    (axs[k]),
      .per   (per[k]),
      .rating(rate[k])
    );
  end

  logic [RL-1:0] cvx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cvx_r <= {cvx_r[RL-2:0], cvx_sp};
    end
  end

  // Pick minima and decide the flip
  logic [RATING_BITS-1:0] cur_min;
  logic [RATING_BITS-1:0] oth_min;

  assign cur_min = (rate[0] < rate[1]) ? rate[0] : rate[1];
  assign oth_min = (rate[2] < rate[3]) ? rate[2] : rate[3];

  always_ff @(posedge clk) begin
    if (en) begin
      is_convex      <= cvx_r[RL-1];
      do_flip        <= cvx_r[RL-1] && (oth_min > cur_min);
      current_rating <= cur_min;
      other_rating   <= oth_min;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qdft_checker.sv =====
`default_nettype none

module qdft_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             is_convex,
  input logic                             do_flip,
  input logic [qdft_pkg::RATING_BITS-1:0] current_rating,
  input logic [qdft_pkg::RATING_BITS-1:0] other_rating
);

  // Flip only for a convex quad whose other diagonal rates strictly better
  a_flip_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (do_flip == (is_convex && (other_rating > current_rating))))
    else $error("flip flag disagrees with ratings");

  // An empty output never holds the input
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input held with empty output");

  // A held result holds the whole pipeline
  a_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

  // A held word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(current_rating) &&
      $stable(other_rating) && $stable(is_convex) && $stable(do_flip)))
    else $error("held word changed");

endmodule

bind quad_diagonal_flip_test_unit qdft_checker u_qdft_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CB = qdft_pkg::COORD_BITS_DEF;
  localparam int RB = qdft_pkg::RATING_BITS;
  localparam int FLIGHT = 40;
  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 1000;

  typedef struct packed {
    logic signed [CB-1:0] ax, az, bx, bz, cx, cz, dx, dz;
  } quad_t;

  typedef struct packed {
    logic          convex;
    logic          flip;
    logic [RB-1:0] cur;
    logic [RB-1:0] oth;
  } verdict_t;

  // directed row: quad plus optional typed-in verdict
  typedef struct {
    quad_t    q;
    bit       has_exp;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic signed [CB-1:0] a_x = '0, a_z = '0, b_x = '0, b_z = '0;
  logic signed [CB-1:0] c_x = '0, c_z = '0, d_x = '0, d_z = '0;
  logic is_convex, do_flip;
  logic [RB-1:0] current_rating, other_rating;

  verdict_t verdicts_due[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_flip = 0;
  int idle_cycles = 0;
  int mode = 0;        // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit hold_off = 1'b0; // long receiver hold-off
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quad_diagonal_flip_test_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_x(a_x), .a_z(a_z), .b_x(b_x), .b_z(b_z),
    .c_x(c_x), .c_z(c_z), .d_x(d_x), .d_z(d_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_convex(is_convex), .do_flip(do_flip),
    .current_rating(current_rating), .other_rating(other_rating)
  );

  // floor(sqrt(v) * 256)
  function automatic longint unsigned side_q8(longint unsigned v);
    logic [79:0] n;
    logic [79:0] root;
    logic [79:0] bitv;
    n = {16'd0, v} << 16;
    root = '0;
    bitv = 80'd1 << 78;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  function automatic longint unsigned span(longint x0, longint z0, longint x1, longint z1);
    longint ddx, ddz;
    ddx = x1 - x0;
    ddz = z1 - z0;
    return side_q8(longint'(ddx * ddx + ddz * ddz));
  endfunction

  function automatic longint turn(longint ox, longint oz, longint px, longint pz,
                                  longint qx, longint qz);
    return (px - ox) * (qz - oz) - (pz - oz) * (qx - ox);
  endfunction

  // shape rating in Q0.16, saturating
  function automatic logic [RB-1:0] shape(longint x2, longint unsigned per);
    logic [191:0] num, den, q;
    longint unsigned mag;
    if (per == 0) return '0;
    mag = (x2 < 0) ? longint'(-x2) : x2;
    num = (192'(qdft_pkg::K6R3) * mag) << (16 + qdft_pkg::RATING_FRAC_DEF);
    den = (192'(per) * per) << qdft_pkg::K6R3_FRAC;
    q = num / den;
    return (q >= 192'(qdft_pkg::RATING_MAX)) ? qdft_pkg::RATING_MAX : q[RB-1:0];
  endfunction

  function automatic verdict_t judge_quad(quad_t q);
    longint x[4], z[4], t;
    longint unsigned s0, s1, s2, s3, bd, ac;
    logic [RB-1:0] r1, r2;
    int pos, neg;
    verdict_t v;
    x[0] = longint'(q.ax); z[0] = longint'(q.az);
    x[1] = longint'(q.bx); z[1] = longint'(q.bz);
    x[2] = longint'(q.cx); z[2] = longint'(q.cz);
    x[3] = longint'(q.dx); z[3] = longint'(q.dz);
    pos = 0;
    neg = 0;
    for (int i = 0; i < 4; i++) begin
      t = turn(x[(i + 3) % 4], z[(i + 3) % 4], x[i], z[i], x[(i + 1) % 4], z[(i + 1) % 4]);
      if (t > 0) pos++;
      else if (t < 0) neg++;
    end
    v.convex = (pos == 4) || (neg == 4);
    s0 = span(x[0], z[0], x[1], z[1]);
    s1 = span(x[1], z[1], x[2], z[2]);
    s2 = span(x[2], z[2], x[3], z[3]);
    s3 = span(x[3], z[3], x[0], z[0]);
    bd = span(x[1], z[1], x[3], z[3]);
    ac = span(x[0], z[0], x[2], z[2]);
    r1 = shape(turn(x[0], z[0], x[1], z[1], x[3], z[3]), s0 + s3 + bd);
    r2 = shape(turn(x[1], z[1], x[2], z[2], x[3], z[3]), s1 + s2 + bd);
    v.cur = (r1 < r2) ? r1 : r2;
    r1 = shape(turn(x[0], z[0], x[1], z[1], x[2], z[2]), s0 + s1 + ac);
    r2 = shape(turn(x[2], z[2], x[3], z[3], x[0], z[0]), s2 + s3 + ac);
    v.oth = (r1 < r2) ? r1 : r2;
    v.flip = v.convex && (v.oth > v.cur);
    return v;
  endfunction

  function automatic logic signed [CB-1:0] rnd_coord(int span_bits);
    logic signed [CB-1:0] c;
    c = CB'($urandom);
    if (span_bits < CB) c = $signed(c) >>> (CB - span_bits);
    return c;
  endfunction

  // random quad, mostly jittered points around a circle-like square
  function automatic quad_t rnd_quad();
    quad_t q;
    int sel, r;
    logic signed [CB-1:0] cx0, cz0;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      q = {$urandom, $urandom, $urandom, $urandom};
      if (sel == 0) begin
        r = $urandom_range(2, CB);
        q.ax = rnd_coord(r); q.az = rnd_coord(r); q.bx = rnd_coord(r); q.bz = rnd_coord(r);
        q.cx = rnd_coord(r); q.cz = rnd_coord(r); q.dx = rnd_coord(r); q.dz = rnd_coord(r);
      end
    end else begin
      r = 1 << $urandom_range(2, 13);
      cx0 = rnd_coord(14);
      cz0 = rnd_coord(14);
      q.ax = CB'(cx0 - r + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.az = CB'(cz0 + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.bx = CB'(cx0 + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.bz = CB'(cz0 - r + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.cx = CB'(cx0 + r + $signed(int'($urandom_range(0, 2 * r))) - r);
      q.cz = CB'(cz0 + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.dx = CB'(cx0 + $signed(int'($urandom_range(0, r / 2))) - r / 4);
      q.dz = CB'(cz0 + r + $signed(int'($urandom_range(0, 2 * r))) - r);
      if (sel == 9) q.cz = q.az; // push toward degenerate corners
    end
    return q;
  endfunction

  task automatic offer(quad_t q, verdict_t v);
    int idle_pct;
    idle_pct = (mode == 1) ? 76 : (mode == 3) ? 23 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {a_x, a_z, b_x, b_z, c_x, c_z, d_x, d_z} <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdicts_due.push_back(v);
    n_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int count);
    quad_t q;
    for (int i = 0; i < count; i++) begin
      q = rnd_quad();
      offer(q, judge_quad(q));
    end
  endtask

  row_t rows[$];

  // directed table and random phases
  initial begin
    row_t rw;
    verdict_t zero_v;
    zero_v = '0;
    // all corners on one point: zero perimeter, zero ratings
    rw.q = '0; rw.has_exp = 1; rw.v = zero_v; rows.push_back(rw);
    // collinear: not convex, zero area
    rw.q = {16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd2, 16'sd0, 16'sd3, 16'sd0};
    rw.has_exp = 1; rw.v = zero_v; rows.push_back(rw);
    // extreme corners square
    rw.q = {-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
            16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767};
    rw.has_exp = 0; rows.push_back(rw);
    rw.q = {16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
            16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767};
    rows.push_back(rw);
    // unit square, both diagonals alike
    rw.q = {16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd1}; rows.push_back(rw);
    // thin rhombus: keep
    rw.q = {-16'sd100, 16'sd0, 16'sd0, -16'sd10, 16'sd100, 16'sd0, 16'sd0, 16'sd10};
    rows.push_back(rw);
    // fat rhombus: flip expected
    rw.q = {-16'sd10, 16'sd0, 16'sd0, -16'sd100, 16'sd10, 16'sd0, 16'sd0, 16'sd100};
    rows.push_back(rw);
    // concave
    rw.q = {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd1, 16'sd0, 16'sd10, -16'sd10};
    rows.push_back(rw);
    // self-crossing bow tie
    rw.q = {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'sd10};
    rows.push_back(rw);
    // repeated corner: degenerate, not convex
    rw.q = {16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 16'sd0, 16'sd0, 16'sd9}; rows.push_back(rw);
    // near equilateral pair, rating near saturation
    rw.q = {16'sd0, 16'sd0, 16'sd1000, -16'sd1732, 16'sd2000, 16'sd0, 16'sd1000, 16'sd1732};
    rows.push_back(rw);
    // all bits set / alternating patterns
    rw.q = {8{16'hFFFF}}; rows.push_back(rw);
    rw.q = {16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA};
    rows.push_back(rw);
    rw.q = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF};
    rows.push_back(rw);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) offer(rows[i].q, rows[i].has_exp ? rows[i].v : judge_quad(rows[i].q));
    drain();

    for (mode = 0; mode < 4; mode++) run_random(N_RANDOM / 5);

    // long receiver hold-off while the sender keeps offering
    mode = 0;
    hold_off = 1'b1;
    run_random(N_RANDOM / 5);
    drain();
    // sender pauses until every result is back, then a final burst
    run_random(30);
    drain();
    repeat (FLIGHT) @(posedge clk);
    stim_done = 1'b1;
  end

  // receiver stall
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_off && cnt < 300) begin
        out_stall <= 1'b1;
        cnt++;
      end else begin
        out_stall <= (mode == 2) ? ($urandom_range(0, 99) < 76) :
                     (mode == 3) ? ($urandom_range(0, 99) < 23) : 1'b0;
      end
    end
  end

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      n_out++;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due: %b %b %0d %0d", $realtime,
                 is_convex, do_flip, current_rating, other_rating);
      end else begin
        want = verdicts_due.pop_front();
        if (want.flip) n_flip++;
        if (is_convex !== want.convex) begin
          errors++;
          $display("%0t: is_convex exp %b got %b", $realtime, want.convex, is_convex);
        end
        if (do_flip !== want.flip) begin
          errors++;
          $display("%0t: do_flip exp %b got %b", $realtime, want.flip, do_flip);
        end
        if (current_rating !== want.cur) begin
          errors++;
          $display("%0t: current_rating exp %0d got %0d", $realtime, want.cur, current_rating);
        end
        if (other_rating !== want.oth) begin
          errors++;
          $display("%0t: other_rating exp %0d got %0d", $realtime, want.oth, other_rating);
        end
      end
    end
  end

  // watchdog and final report
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (stim_done || idle_cycles >= WATCHDOG) begin
      if (idle_cycles >= WATCHDOG) $display("%0t: watchdog expired", $realtime);
      $display("Covered %0d quads, %0d results, %0d flips, through all idle/stall mixes.",
               n_in, n_out, n_flip);
      if (errors == 0 && verdicts_due.size() == 0 && idle_cycles < WATCHDOG)
        $display("DONE: 0 errors");
      else
        $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/qdft_pkg.sv
hw/rtl/qdft_isqrt.sv
hw/rtl/qdft_rating.sv
hw/rtl/quad_diagonal_flip_test_unit.sv
hw/rtl/qdft_checker.sv
bench/tb_top.sv
